/* rtl/smspm_pkg.sv */
`default_nettype none

package smspm_pkg;

  // number of interleaved stereo pairs held by the meter
  localparam int PAIRS = 4;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int PEAK_W = 16;
  localparam int TALLY_W = 8;

  // item codes carried on in_mode
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_EOB    = 2'd1,
    MODE_READ   = 2'd2,
    MODE_REARM  = 2'd3
  } mode_t;

  // four magnitudes of one stereo sample
  typedef struct packed {
    logic [PEAK_W-1:0] left;
    logic [PEAK_W-1:0] right;
    logic [PEAK_W-1:0] mid;
    logic [PEAK_W-1:0] side;
  } mag_t;

endpackage

`default_nettype wire

/* rtl/smspm_mag_calc.sv */
`default_nettype none

module smspm_mag_calc
  import smspm_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] left_sample,
  input  wire logic signed [SAMPLE_W-1:0] right_sample,
  output mag_t                            mags
);

  logic signed [SAMPLE_W+1:0] l_ext;
  logic signed [SAMPLE_W+1:0] r_ext;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [SAMPLE_W+1:0] diff;
  logic        [SAMPLE_W+1:0] l_abs;
  logic        [SAMPLE_W+1:0] r_abs;
  logic        [SAMPLE_W+1:0] sum_abs;
  logic        [SAMPLE_W+1:0] diff_abs;

  // widen so that sum, difference and negation cannot overflow
  always_comb begin
    l_ext = {{2{left_sample[SAMPLE_W-1]}}, left_sample};
    r_ext = {{2{right_sample[SAMPLE_W-1]}}, right_sample};
    sum   = l_ext + r_ext;
    diff  = l_ext - r_ext;
  end

  // magnitudes; halving the magnitude truncates toward zero
  always_comb begin
    l_abs    = l_ext[SAMPLE_W+1] ? 18'(-l_ext) : 18'(l_ext);
    r_abs    = r_ext[SAMPLE_W+1] ? 18'(-r_ext) : 18'(r_ext);
    sum_abs  = sum[SAMPLE_W+1]   ? 18'(-sum)   : 18'(sum);
    diff_abs = diff[SAMPLE_W+1]  ? 18'(-diff)  : 18'(diff);
    mags.left  = l_abs[PEAK_W-1:0];
    mags.right = r_abs[PEAK_W-1:0];
    mags.mid   = sum_abs[PEAK_W:1];
    mags.side  = diff_abs[PEAK_W:1];
  end

endmodule

`default_nettype wire

/* rtl/stereo_mid_side_peak_meter.sv */
// an accepted word sits in the input register, and its result word loads the result register as it leaves
// throughput: one word per cycle; every word reads and updates the peak registers in one pass
// stalls: a held-off result word holds the input register, which then stalls the input
// reset (rst_n low, synchronous): all held peaks zero, block tally zero, meter armed,
//   blocks_per_publish 1, pipeline empty
`default_nettype none

module stereo_mid_side_peak_meter
  import smspm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [1:0]                 in_pair_index,
  input  wire logic signed [SAMPLE_W-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_right_sample,
  input  wire logic                       in_clear_peaks,

  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [PEAK_W-1:0]               out_left_peak,
  output logic [PEAK_W-1:0]               out_right_peak,
  output logic [PEAK_W-1:0]               out_mid_peak,
  output logic [PEAK_W-1:0]               out_side_peak,
  output logic                            out_armed,

  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [TALLY_W-1:0]         cfg_blocks_per_publish
);

  // input register
  logic                       s1_valid_r;
  mode_t                      s1_mode_r;
  logic [1:0]                 s1_pair_r;
  logic signed [SAMPLE_W-1:0] s1_left_r;
  logic signed [SAMPLE_W-1:0] s1_right_r;
  logic                       s1_clear_r;

  // meter state
  logic [PEAK_W-1:0]  left_hold_r  [PAIRS];
  logic [PEAK_W-1:0]  right_hold_r [PAIRS];
  logic [PEAK_W-1:0]  mid_hold_r   [PAIRS];
  logic [PEAK_W-1:0]  side_hold_r  [PAIRS];
  logic [PEAK_W-1:0]  left_hold_nxt  [PAIRS];
  logic [PEAK_W-1:0]  right_hold_nxt [PAIRS];
  logic [PEAK_W-1:0]  mid_hold_nxt   [PAIRS];
  logic [PEAK_W-1:0]  side_hold_nxt  [PAIRS];
  logic [TALLY_W-1:0] tally_r;
  logic [TALLY_W-1:0] tally_nxt;
  logic               armed_r;
  logic               armed_nxt;
  logic [TALLY_W-1:0] bpp_r;

  // result register
  logic               out_valid_r;
  logic [PEAK_W-1:0]  out_left_r;
  logic [PEAK_W-1:0]  out_right_r;
  logic [PEAK_W-1:0]  out_mid_r;
  logic [PEAK_W-1:0]  out_side_r;
  logic               out_armed_r;
  mag_t               res_nxt;

  logic               s1_load;
  logic               s2_adv;
  logic               pair_ok;
  logic [PAIR_W-1:0]  idx;
  logic [TALLY_W-1:0] tally_inc;
  mag_t               mags;

  // handshake
  always_comb begin
    s2_adv    = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall  = s1_valid_r && !s2_adv;
    s1_load   = in_valid && !in_stall;
    cfg_ready = 1'b1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mode_r  <= mode_t'(in_mode);
      s1_pair_r  <= in_pair_index;
      s1_left_r  <= in_left_sample;
      s1_right_r <= in_right_sample;
      s1_clear_r <= in_clear_peaks;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= TALLY_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      bpp_r <= cfg_blocks_per_publish;
    end
  end

  smspm_mag_calc u_mag_calc (
    .left_sample  (s1_left_r),
    .right_sample (s1_right_r),
    .mags         (mags)
  );

  // pair decode
  always_comb begin
    pair_ok = ({30'd0, s1_pair_r} < PAIRS);
    idx     = s1_pair_r[PAIR_W-1:0];
  end

  // next meter state for the word in the input register
  always_comb begin
    left_hold_nxt  = left_hold_r;
    right_hold_nxt = right_hold_r;
    mid_hold_nxt   = mid_hold_r;
    side_hold_nxt  = side_hold_r;
    tally_nxt      = tally_r;
    armed_nxt      = armed_r;
    tally_inc      = tally_r + TALLY_W'(1);
    case (s1_mode_r)
      MODE_SAMPLE: begin
        if (armed_r && pair_ok) begin
          if (mags.left > left_hold_r[idx]) left_hold_nxt[idx] = mags.left;
          if (mags.right > right_hold_r[idx]) right_hold_nxt[idx] = mags.right;
          if (mags.mid > mid_hold_r[idx]) mid_hold_nxt[idx] = mags.mid;
          if (mags.side > side_hold_r[idx]) side_hold_nxt[idx] = mags.side;
        end
      end
      MODE_EOB: begin
        if (armed_r) begin
          if (tally_inc == bpp_r) begin
            tally_nxt = '0;
            armed_nxt = 1'b0;
          end else begin
            tally_nxt = tally_inc;
          end
        end
      end
      MODE_REARM: begin
        armed_nxt = 1'b1;
        if (s1_clear_r) begin
          for (int p = 0; p < PAIRS; p++) begin
            left_hold_nxt[p]  = '0;
            right_hold_nxt[p] = '0;
            mid_hold_nxt[p]   = '0;
            side_hold_nxt[p]  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields from the updated state
  always_comb begin
    if (pair_ok) begin
      res_nxt.left  = left_hold_nxt[idx];
      res_nxt.right = right_hold_nxt[idx];
      res_nxt.mid   = mid_hold_nxt[idx];
      res_nxt.side  = side_hold_nxt[idx];
    end else begin
      res_nxt = '0;
    end
  end

  // meter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAIRS; p++) begin
        left_hold_r[p]  <= '0;
        right_hold_r[p] <= '0;
        mid_hold_r[p]   <= '0;
        side_hold_r[p]  <= '0;
      end
      tally_r <= '0;
      armed_r <= 1'b1;
    end else if (s2_adv) begin
      left_hold_r  <= left_hold_nxt;
      right_hold_r <= right_hold_nxt;
      mid_hold_r   <= mid_hold_nxt;
      side_hold_r  <= side_hold_nxt;
      tally_r      <= tally_nxt;
      armed_r      <= armed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_left_r  <= res_nxt.left;
      out_right_r <= res_nxt.right;
      out_mid_r   <= res_nxt.mid;
      out_side_r  <= res_nxt.side;
      out_armed_r <= armed_nxt;
    end
  end

  always_comb begin
    out_valid      = out_valid_r;
    out_left_peak  = out_left_r;
    out_right_peak = out_right_r;
    out_mid_peak   = out_mid_r;
    out_side_peak  = out_side_r;
    out_armed      = out_armed_r;
  end

  // a frozen meter always holds a cleared tally
  a_frozen_tally_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> tally_r == '0)
    else $error("block tally nonzero while frozen");

  // a re-arm word always leaves the meter armed
  a_rearm_arms: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && s1_mode_r == MODE_REARM |=> armed_r && out_valid_r && out_armed_r)
    else $error("re-arm word did not arm the meter");

  // held peaks stay within the magnitude range of a 16-bit sample
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_left_r <= 16'd32768 && out_right_r <= 16'd32768 &&
                    out_mid_r <= 16'd32768 && out_side_r <= 16'd32767)
    else $error("held peak out of range");

endmodule

`default_nettype wire

/* sim/tb_stereo_mid_side_peak_meter.sv */
`default_nettype none

import smspm_pkg::*;

// tracks the held peaks, the block tally and the armed flag, and queues
// the peak word that each accepted input word should produce
class meter_scoreboard;
  typedef struct {
    logic [PEAK_W-1:0] left;
    logic [PEAK_W-1:0] right;
    logic [PEAK_W-1:0] mid;
    logic [PEAK_W-1:0] side;
    logic              armed;
  } peak_word_t;

  logic [PEAK_W-1:0]  left_hold  [PAIRS];
  logic [PEAK_W-1:0]  right_hold [PAIRS];
  logic [PEAK_W-1:0]  mid_hold   [PAIRS];
  logic [PEAK_W-1:0]  side_hold  [PAIRS];
  logic [TALLY_W-1:0] tally;
  logic [TALLY_W-1:0] blocks_per_publish;
  bit                 armed_flag;

  peak_word_t expected_peaks[$];
  int errors;
  int words_in;
  int words_out;
  int frozen_words;

  function new();
    clear_peaks_all();
    tally = '0;
    blocks_per_publish = 8'd1;
    armed_flag = 1'b1;
    errors = 0;
    words_in = 0;
    words_out = 0;
    frozen_words = 0;
  endfunction

  function void clear_peaks_all();
    for (int i = 0; i < PAIRS; i++) begin
      left_hold[i] = '0;
      right_hold[i] = '0;
      mid_hold[i] = '0;
      side_hold[i] = '0;
    end
  endfunction

  function void set_blocks(logic [TALLY_W-1:0] v);
    blocks_per_publish = v;
  endfunction

  function int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // apply one accepted input word and queue the expected peak word
  function void note_word(mode_t mode, logic [1:0] pair, logic signed [SAMPLE_W-1:0] l,
                          logic signed [SAMPLE_W-1:0] r, bit clr);
    int a;
    int b;
    int m;
    int s;
    bit pair_ok;
    peak_word_t w;
    pair_ok = (int'(pair) < PAIRS);
    words_in++;
    case (mode)
      MODE_SAMPLE: begin
        if (armed_flag && pair_ok) begin
          a = magnitude(int'(l));
          b = magnitude(int'(r));
          m = magnitude(int'(l) + int'(r)) / 2;
          s = magnitude(int'(l) - int'(r)) / 2;
          if (a > left_hold[pair]) left_hold[pair] = a[PEAK_W-1:0];
          if (b > right_hold[pair]) right_hold[pair] = b[PEAK_W-1:0];
          if (m > mid_hold[pair]) mid_hold[pair] = m[PEAK_W-1:0];
          if (s > side_hold[pair]) side_hold[pair] = s[PEAK_W-1:0];
        end
      end
      MODE_EOB: begin
        // wrapping tally, compared for equality only
        if (armed_flag) begin
          tally = tally + 8'd1;
          if (tally == blocks_per_publish) begin
            tally = '0;
            armed_flag = 1'b0;
          end
        end
      end
      MODE_REARM: begin
        armed_flag = 1'b1;
        if (clr) clear_peaks_all();
      end
      default: ;
    endcase
    if (pair_ok) begin
      w.left = left_hold[pair];
      w.right = right_hold[pair];
      w.mid = mid_hold[pair];
      w.side = side_hold[pair];
    end else begin
      w.left = '0;
      w.right = '0;
      w.mid = '0;
      w.side = '0;
    end
    w.armed = armed_flag;
    expected_peaks = {expected_peaks, w};
  endfunction

  function void compare_field(string name, logic [PEAK_W-1:0] want, logic [PEAK_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare one accepted result word with the oldest expectation
  function void check_word(logic [PEAK_W-1:0] l, logic [PEAK_W-1:0] r,
                           logic [PEAK_W-1:0] m, logic [PEAK_W-1:0] s, logic armed);
    peak_word_t w;
    if (expected_peaks.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d armed %0b",
               $time, l, r, m, s, armed);
      return;
    end
    w = expected_peaks.pop_front();
    words_out++;
    if (!armed) frozen_words++;
    compare_field("left_peak", w.left, l);
    compare_field("right_peak", w.right, r);
    compare_field("mid_peak", w.mid, m);
    compare_field("side_peak", w.side, s);
    compare_field("armed", {15'd0, w.armed}, {15'd0, armed});
  endfunction
endclass

module tb_stereo_mid_side_peak_meter;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_mode = '0;
  logic [1:0]                 in_pair_index = '0;
  logic signed [SAMPLE_W-1:0] in_left_sample = '0;
  logic signed [SAMPLE_W-1:0] in_right_sample = '0;
  logic                       in_clear_peaks = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [PEAK_W-1:0]          out_left_peak;
  logic [PEAK_W-1:0]          out_right_peak;
  logic [PEAK_W-1:0]          out_mid_peak;
  logic [PEAK_W-1:0]          out_side_peak;
  logic                       out_armed;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [TALLY_W-1:0]         cfg_blocks_per_publish = 8'd1;

  meter_scoreboard sb = new();

  int cycle_count = 0;
  int cfg_writes = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  stereo_mid_side_peak_meter DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_pair_index          (in_pair_index),
    .in_left_sample         (in_left_sample),
    .in_right_sample        (in_right_sample),
    .in_clear_peaks         (in_clear_peaks),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_left_peak          (out_left_peak),
    .out_right_peak         (out_right_peak),
    .out_mid_peak           (out_mid_peak),
    .out_side_peak          (out_side_peak),
    .out_armed              (out_armed),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_blocks_per_publish (cfg_blocks_per_publish)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_left_peak, out_right_peak, out_mid_peak, out_side_peak, out_armed);
  end

  // offer one word at a falling edge and hold it until accepted
  task automatic send_word(mode_t mode, logic [1:0] pair, logic signed [SAMPLE_W-1:0] l,
                           logic signed [SAMPLE_W-1:0] r, bit clr);
    in_mode <= mode;
    in_pair_index <= pair;
    in_left_sample <= l;
    in_right_sample <= r;
    in_clear_peaks <= clr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(mode, pair, l, r, clr);
    @(negedge clk);
  endtask

  // sender gap between words
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // drain all outstanding words, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_peaks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_blocks(logic [TALLY_W-1:0] v);
    wait_idle();
    cfg_blocks_per_publish <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_blocks(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int eob_pct);
    int pick;
    mode_t mode;
    pick = $urandom_range(0, 99);
    if (pick < eob_pct) mode = MODE_EOB;
    else if (pick < eob_pct + 8) mode = MODE_REARM;
    else if (pick < eob_pct + 18) mode = MODE_READ;
    else mode = MODE_SAMPLE;
    send_word(mode, 2'($urandom_range(0, 3)), pick_sample(), pick_sample(),
              1'($urandom_range(0, 1)));
    maybe_gap();
  endtask

  task automatic run_phase(logic [TALLY_W-1:0] blocks, int count, int eob_pct, bit long_hold);
    write_blocks(blocks);
    for (int i = 0; i < count; i++) begin
      if (long_hold && i == 10) hold_req = 1'b1;
      send_random(eob_pct);
    end
  endtask

  // extremes of the samples, every mode, frozen and re-arm cases
  task automatic run_directed();
    send_word(MODE_READ, 2'd0, 16'sd0, 16'sd0, 1'b0);
    send_word(MODE_SAMPLE, 2'd0, 16'sh7fff, 16'sh7fff, 1'b0);
    send_word(MODE_SAMPLE, 2'd1, 16'sh8000, 16'sh8000, 1'b0);
    send_word(MODE_SAMPLE, 2'd2, 16'sh7fff, 16'sh8000, 1'b0);
    send_word(MODE_SAMPLE, 2'd3, 16'sh8000, 16'sh7fff, 1'b1);
    // half sums of -1 truncate toward zero
    send_word(MODE_SAMPLE, 2'd3, -16'sd1, 16'sd0, 1'b0);
    send_word(MODE_SAMPLE, 2'd0, 16'sd3, -16'sd4, 1'b0);
    for (int p = 0; p < 4; p++) send_word(MODE_READ, 2'(p), 16'sh8000, 16'sh7fff, 1'b1);
    // one block per publish: this freezes the meter
    send_word(MODE_EOB, 2'd0, 16'sd0, 16'sd0, 1'b0);
    // samples and block ends while frozen are ignored
    send_word(MODE_SAMPLE, 2'd0, 16'sh8000, 16'sh8000, 1'b0);
    send_word(MODE_EOB, 2'd1, 16'sd0, 16'sd0, 1'b0);
    send_word(MODE_READ, 2'd0, 16'sd0, 16'sd0, 1'b0);
    // re-arm keeping peaks, then re-arm while armed with clear
    send_word(MODE_REARM, 2'd1, 16'sd0, 16'sd0, 1'b0);
    send_word(MODE_REARM, 2'd2, 16'sh7fff, 16'sh8000, 1'b1);
    send_word(MODE_READ, 2'd1, 16'sd0, 16'sd0, 1'b1);
    send_word(MODE_SAMPLE, 2'd1, 16'sd100, -16'sd300, 1'b1);
    send_word(MODE_SAMPLE, 2'd1, 16'sd50, -16'sd20, 1'b0);
    send_word(MODE_READ, 2'd3, 16'sh7fff, 16'sh7fff, 1'b0);
    send_word(MODE_EOB, 2'd2, 16'sh8000, 16'sh8000, 1'b1);
    send_word(MODE_REARM, 2'd3, 16'sd0, 16'sd0, 1'b0);
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_phase(8'd3, 100, 12, 1'b1);
    run_phase(8'd1, 40, 10, 1'b0);
    run_phase(8'd255, 40, 35, 1'b0);
    // zero count, also below the running tally: the tally runs toward its 8-bit wrap
    run_phase(8'd0, 180, 90, 1'b0);
    wait_idle();
    calm = 1'b1;
    run_phase(8'd2, 40, 15, 1'b0);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("checked %0d result words for %0d input words over %0d register writes",
             sb.words_out, sb.words_in, cfg_writes);
    $display("%0d results came back frozen; block counts 0, 1, 2, 3 and 255 were run",
             sb.frozen_words);
    if (sb.errors == 0 && sb.expected_peaks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
